// ----- design/esic_pkg.sv -----
// shared types, constants and a helper function for the interrupt controller
`timescale 1ns / 1ps

package esic_pkg;

   // default source count and fixed field widths
   localparam int NUM_SOURCES_DEF = 8;
   localparam int VEC_COUNT       = 8;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   // reset values of the control bytes
   localparam logic [7:0] MASK_RESET = 8'hFF;
   localparam logic [7:0] MODE_RESET = 8'h80;

   // configuration register indexes
   localparam logic CFG_VECTOR_BASE = 1'b0;

   // request kinds
   typedef enum logic [2:0] {
      REQ_READ  = 3'd0,
      REQ_WRITE = 3'd1,
      REQ_RAISE = 3'd2,
      REQ_DROP  = 3'd3,
      REQ_ACK   = 3'd4
   } req_kind_type;

   // command register opcodes, upper nibble of the written byte
   typedef enum logic [3:0] {
      CMD_RESET        = 4'd0,
      CMD_CLR_PEND_MSK = 4'd2,
      CMD_SET_MASK     = 4'd3,
      CMD_CLR_PEND     = 4'd4,
      CMD_CLR_SERVICE  = 4'd7,
      CMD_MODE_LOW_A   = 4'd8,
      CMD_MODE_LOW_B   = 4'd9,
      CMD_MODE_HIGH    = 4'd10,
      CMD_PTR_MASK     = 4'd11,
      CMD_PTR_AUTOCLR  = 4'd12,
      CMD_PTR_VECTOR   = 4'd14
   } cmd_code_type;

   // data register pointer targets
   localparam logic [3:0] PTR_MASK    = 4'd8;
   localparam logic [3:0] PTR_AUTOCLR = 4'd9;

   // data register read selection, mode bits 6..5
   localparam logic [1:0] RSEL_SERVICE = 2'd0;
   localparam logic [1:0] RSEL_MASK    = 2'd1;
   localparam logic [1:0] RSEL_PENDING = 2'd2;

   // master mask control, command data bits 1..0
   localparam logic [1:0] MASTER_SET = 2'd1;
   localparam logic [1:0] MASTER_CLR = 2'd2;

   // priority encoder, lowest set bit wins
   function automatic logic [2:0] lowest_idx(input logic [7:0] bits);
      logic [2:0] idx;
      idx = '0;
      for (int i = 7; i >= 0; i--) begin
         if (bits[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ----- design/esic_req_if.sv -----
// request channel interface: handshake plus request fields
`timescale 1ns / 1ps

interface esic_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic        reg_sel;
   logic [15:0] wdata;
   logic [2:0]  src;

   modport source (output valid, req_type, reg_sel, wdata, src, input ready);
   modport sink   (input valid, req_type, reg_sel, wdata, src, output ready);
endinterface

// ----- design/esic_rsp_if.sv -----
// response channel interface: handshake plus result fields
`timescale 1ns / 1ps

interface esic_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rdata;
   logic        irq;
   logic        ack_valid;
   logic [15:0] ack_vector;

   modport source (output valid, rdata, irq, ack_valid, ack_vector, input ready);
   modport sink   (input valid, rdata, irq, ack_valid, ack_vector, output ready);
endinterface

// ----- design/eight_source_interrupt_controller.sv -----
// top level of the eight-source interrupt controller
`timescale 1ns / 1ps

// Eight-source interrupt controller. Each request (register read, register
// write, raise source, drop source or acknowledge) is decoded and applied to
// the controller state in the cycle it is accepted, and its response lands in
// a single output register in the cycle after. One request is taken every
// clock cycle while req ready is high, which it stays as long as the response
// register is empty or being drained in the same cycle, so a stalled response
// holds off only the next request. irq in each response is the group interrupt
// after that request. The vector base is written through the APB-style port at
// byte address 0 and should only change while no request is outstanding.
module eight_source_interrupt_controller #(
   parameter int NUM_SOURCES = esic_pkg::NUM_SOURCES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   esic_req_if.sink                           req_chan,
   esic_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [esic_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [esic_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [esic_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import esic_pkg::*;

   logic [15:0] vector_base;

   // configuration register
   esic_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .vector_base (vector_base)
   );

   // controller datapath
   esic_core #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .vector_base (vector_base)
   );

endmodule

// ----- design/esic_csr.sv -----
// apb-style configuration port holding the vector base register
`timescale 1ns / 1ps

module esic_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [esic_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [esic_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [esic_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [15:0]                        vector_base
);
   import esic_pkg::*;

   logic [15:0] base_ff, base_in;
   logic        wr_en;
   logic        sel_base;

   // register index is the word address
   assign sel_base = (csr_paddr[CSR_ADDR_W-1] == CFG_VECTOR_BASE);
   assign wr_en    = csr_psel & csr_penable & csr_pwrite & sel_base;

   assign base_in = wr_en ? csr_pwdata[15:0] : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   // read back
   assign csr_prdata  = sel_base ? {{(CSR_DATA_W-16){1'b0}}, base_ff} : '0;
   assign csr_pready  = 1'b1;
   assign vector_base = base_ff;

endmodule

// ----- design/esic_core.sv -----
// controller state, request decode and registered response
`timescale 1ns / 1ps

module esic_core #(
   parameter int NUM_SOURCES = esic_pkg::NUM_SOURCES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   esic_req_if.sink          req_chan,
   esic_rsp_if.source        rsp_chan,
   input  logic [15:0]       vector_base
);
   import esic_pkg::*;

   localparam logic [7:0] SrcMask = 8'((9'd1 << NUM_SOURCES) - 9'd1);

   // controller state
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  mask_ff, mask_in;
   logic [7:0]  svc_ff, svc_in;
   logic [7:0]  aclr_ff, aclr_in;
   logic [7:0]  mode_ff, mode_in;
   logic [3:0]  ptr_ff, ptr_in;
   logic        gv_ff, gv_in;
   logic [2:0]  gidx_ff, gidx_in;
   logic [15:0] vec_ff [VEC_COUNT];

   // response register
   logic        rv_ff, rv_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic        irq_ff;
   logic        ackv_ff, ackv_in;
   logic [15:0] ackvec_ff, ackvec_in;

   logic         accept;
   logic         vec_we;
   logic [2:0]   vec_waddr;
   logic [7:0]   live, live_new, svc_live, bitm, ack_bit;
   logic [2:0]   live_idx, svc_idx;
   logic         eval;
   logic         cmd_one;
   logic         src_ok;
   logic [7:0]   status;
   cmd_code_type cmd;

   // request accepted when the response slot is free or being drained
   assign req_chan.ready = ~rv_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   // priority encode of live requests and in-service bits
   assign live     = pend_ff & ~mask_ff & SrcMask;
   assign live_idx = lowest_idx(live);
   assign svc_live = svc_ff & SrcMask;
   assign svc_idx  = lowest_idx(svc_live);
   assign ack_bit  = 8'b1 << live_idx;

   assign cmd     = cmd_code_type'(req_chan.wdata[7:4]);
   assign cmd_one = req_chan.wdata[3];
   assign bitm    = 8'b1 << req_chan.wdata[2:0];
   assign src_ok  = int'(req_chan.src) < NUM_SOURCES;

   // status byte
   always_comb begin
      status      = {gv_ff, 1'b1, mode_ff[0], mode_ff[2], mode_ff[7], gidx_ff};
      if (gv_ff && (svc_live != 8'd0)) begin
         status[2:0] = gidx_ff | svc_idx;
      end
   end

   // next state and response
   always_comb begin
      pend_in   = pend_ff;
      mask_in   = mask_ff;
      svc_in    = svc_ff;
      aclr_in   = aclr_ff;
      mode_in   = mode_ff;
      ptr_in    = ptr_ff;
      vec_we    = 1'b0;
      vec_waddr = ptr_ff[2:0];
      eval      = 1'b0;
      rdata_in  = '0;
      ackv_in   = 1'b0;
      ackvec_in = '0;

      if (accept) begin
         case (req_kind_type'(req_chan.req_type))
            REQ_READ: begin
               if (req_chan.reg_sel) begin
                  rdata_in = status;
               end else begin
                  case (mode_ff[6:5])
                     RSEL_SERVICE: rdata_in = svc_ff;
                     RSEL_MASK:    rdata_in = mask_ff;
                     RSEL_PENDING: rdata_in = pend_ff;
                     default:      rdata_in = aclr_ff;
                  endcase
               end
            end
            REQ_WRITE: begin
               if (req_chan.reg_sel) begin
                  case (cmd)
                     CMD_RESET: begin
                        mask_in = MASK_RESET;
                        pend_in = '0;
                        svc_in  = '0;
                        aclr_in = '0;
                     end
                     CMD_CLR_PEND_MSK: begin
                        pend_in = cmd_one ? (pend_ff & ~bitm) : 8'd0;
                        mask_in = cmd_one ? (mask_ff & ~bitm) : 8'd0;
                     end
                     CMD_SET_MASK:    mask_in = cmd_one ? (mask_ff | bitm) : 8'hFF;
                     CMD_CLR_PEND:    pend_in = cmd_one ? (pend_ff & ~bitm) : 8'd0;
                     CMD_CLR_SERVICE: svc_in  = cmd_one ? (svc_ff & ~bitm) : 8'd0;
                     CMD_MODE_LOW_A, CMD_MODE_LOW_B: begin
                        mode_in[4:0] = req_chan.wdata[4:0];
                     end
                     CMD_MODE_HIGH: begin
                        mode_in[6:5] = req_chan.wdata[3:2];
                        if (req_chan.wdata[1:0] == MASTER_SET) begin
                           mode_in[7] = 1'b1;
                        end else if (req_chan.wdata[1:0] == MASTER_CLR) begin
                           mode_in[7] = 1'b0;
                        end
                     end
                     CMD_PTR_MASK:    ptr_in = PTR_MASK;
                     CMD_PTR_AUTOCLR: ptr_in = PTR_AUTOCLR;
                     CMD_PTR_VECTOR:  ptr_in = {1'b0, req_chan.wdata[2:0]};
                     default: ;
                  endcase
               end else begin
                  if (ptr_ff == PTR_MASK) begin
                     mask_in = req_chan.wdata[7:0];
                  end else if (ptr_ff == PTR_AUTOCLR) begin
                     aclr_in = req_chan.wdata[7:0];
                  end else if (!ptr_ff[3]) begin
                     vec_we = 1'b1;
                  end
               end
            end
            REQ_RAISE: begin
               if (src_ok) begin
                  pend_in[req_chan.src] = 1'b1;
                  eval = 1'b1;
               end
            end
            REQ_DROP: begin
               if (src_ok) begin
                  pend_in[req_chan.src] = 1'b0;
                  svc_in[req_chan.src]  = 1'b0;
                  eval = 1'b1;
               end
            end
            REQ_ACK: begin
               if (live != 8'd0) begin
                  pend_in = pend_ff & ~ack_bit;
                  svc_in  = ((aclr_ff & ack_bit) != 8'd0) ? (svc_ff & ~ack_bit)
                                                           : (svc_ff | ack_bit);
                  eval      = 1'b1;
                  ackv_in   = 1'b1;
                  ackvec_in = 16'(vec_ff[live_idx] + vector_base);
               end
            end
            default: ;
         endcase
      end
   end

   // group evaluation on the updated request byte
   assign live_new = pend_in & ~mask_ff & SrcMask;
   always_comb begin
      gv_in   = gv_ff;
      gidx_in = gidx_ff;
      if (eval) begin
         gv_in   = mode_ff[7] & ~mode_ff[2] & (live_new != 8'd0);
         gidx_in = gv_in ? lowest_idx(live_new) : 3'd0;
      end
   end

   assign rv_in = accept | (rv_ff & ~rsp_chan.ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         mask_ff <= MASK_RESET;
         svc_ff  <= '0;
         aclr_ff <= '0;
         mode_ff <= MODE_RESET;
         ptr_ff  <= '0;
         gv_ff   <= 1'b0;
         gidx_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         mask_ff <= mask_in;
         svc_ff  <= svc_in;
         aclr_ff <= aclr_in;
         mode_ff <= mode_in;
         ptr_ff  <= ptr_in;
         gv_ff   <= gv_in;
         gidx_ff <= gidx_in;
         rv_ff   <= rv_in;
      end
   end

   // vector table, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VEC_COUNT; i++) begin
            vec_ff[i] <= '0;
         end
      end else if (vec_we) begin
         vec_ff[vec_waddr] <= req_chan.wdata;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff  <= rdata_in;
         irq_ff    <= gv_in;
         ackv_ff   <= ackv_in;
         ackvec_ff <= ackvec_in;
      end
   end

   assign rsp_chan.valid      = rv_ff;
   assign rsp_chan.rdata      = rdata_ff;
   assign rsp_chan.irq        = irq_ff;
   assign rsp_chan.ack_valid  = ackv_ff;
   assign rsp_chan.ack_vector = ackvec_ff;

   // checks
   a_group_idx_clear: assert property (@(posedge clock) disable iff (reset)
      !gv_ff |-> gidx_ff == 3'd0)
      else $error("group index set without group interrupt");

   a_ack_served: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.req_type == REQ_ACK && live != 8'd0 |=> rv_ff && ackv_ff)
      else $error("acknowledge with live request not served");

   a_no_vector_without_ack: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !ackv_ff |-> ackvec_ff == 16'd0)
      else $error("vector returned without acknowledge");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while response stalled");

   a_reset_mask: assert property (@(posedge clock)
      reset |=> mask_ff == MASK_RESET && mode_ff == MODE_RESET)
      else $error("mask or mode not restored by reset");

endmodule

// ----- sim/eight_source_interrupt_controller_tb.sv -----
// self-checking testbench for the eight-source interrupt controller
`timescale 1ns / 1ps

module eight_source_interrupt_controller_tb;
   import esic_pkg::*;

   localparam int NSRC            = NUM_SOURCES_DEF;
   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 9;
   localparam int PHASE_REQUESTS  = 210;
   localparam int LONG_HOLD       = 60;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam logic [CSR_ADDR_W-1:0] BASE_ADDR = CSR_ADDR_W'(int'(CFG_VECTOR_BASE) * 4);

   // request kinds the block ignores, and a command code it ignores
   localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
   localparam logic [3:0] CMD_SPARE        = 4'd13;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        irq;
      logic        ack_valid;
      logic [15:0] ack_vector;
   } irq_result_type;

   // controller state mirror and queue of expected responses
   class irq_scoreboard;
      logic [15:0] base;
      logic [7:0]  pending;
      logic [7:0]  mask;
      logic [7:0]  in_service;
      logic [7:0]  autoclr;
      logic [7:0]  mode;
      logic [7:0]  group;
      logic [3:0]  ptr;
      logic [15:0] vectors [8];
      irq_result_type expected_q [$];
      int          errors;

      function new();
         errors = 0;
         base = '0;
         pending = '0;
         mask = MASK_RESET;
         in_service = '0;
         autoclr = '0;
         mode = MODE_RESET;
         group = '0;
         ptr = '0;
         foreach (vectors[i]) vectors[i] = '0;
      endfunction

      function int lowest_set(logic [7:0] bits);
         for (int i = 0; i < NSRC; i++) begin
            if (bits[i]) return i;
         end
         return -1;
      endfunction

      function logic [7:0] live_bits();
         return pending & ~mask & 8'((1 << NSRC) - 1);
      endfunction

      // group status: master enabled and not polled gives irq plus lowest index
      function void regroup();
         int idx;
         group = group & ~8'h87;
         if (mode[7] && !mode[2]) begin
            idx = lowest_set(live_bits());
            if (idx >= 0) group = group | 8'h80 | 8'(idx);
         end
      endfunction

      function logic [7:0] read_register(logic sel);
         logic [7:0] v;
         int idx;
         if (!sel) begin
            case (mode[6:5])
               RSEL_SERVICE: return in_service;
               RSEL_MASK:    return mask;
               RSEL_PENDING: return pending;
               default:      return autoclr;
            endcase
         end
         v = group | 8'h40;
         if (mode[0]) v = v | 8'h20;
         if (mode[2]) v = v | 8'h10;
         if (mode[7]) v = v | 8'h08;
         if (group[7]) begin
            idx = lowest_set(in_service);
            if (idx >= 0) v = v | 8'(idx);
         end
         return v;
      endfunction

      function void write_command(logic [15:0] d);
         logic       one;
         logic [7:0] sel_bit;
         one = d[3];
         sel_bit = 8'd1 << d[2:0];
         case (d[7:4])
            CMD_RESET: begin
               mask = MASK_RESET;
               pending = '0;
               in_service = '0;
               autoclr = '0;
            end
            CMD_CLR_PEND_MSK: begin
               if (one) begin
                  pending = pending & ~sel_bit;
                  mask = mask & ~sel_bit;
               end else begin
                  pending = '0;
                  mask = '0;
               end
            end
            CMD_SET_MASK:    mask = one ? (mask | sel_bit) : MASK_RESET;
            CMD_CLR_PEND:    pending = one ? (pending & ~sel_bit) : 8'h00;
            CMD_CLR_SERVICE: in_service = one ? (in_service & ~sel_bit) : 8'h00;
            CMD_MODE_LOW_A, CMD_MODE_LOW_B: mode[4:0] = d[4:0];
            CMD_MODE_HIGH: begin
               mode[6:5] = d[3:2];
               if (d[1:0] == MASTER_SET) mode[7] = 1'b1;
               else if (d[1:0] == MASTER_CLR) mode[7] = 1'b0;
            end
            CMD_PTR_MASK:    ptr = PTR_MASK;
            CMD_PTR_AUTOCLR: ptr = PTR_AUTOCLR;
            CMD_PTR_VECTOR:  ptr = {1'b0, d[2:0]};
            default: ;
         endcase
      endfunction

      function void write_data(logic [15:0] d);
         if (ptr == PTR_MASK) mask = d[7:0];
         else if (ptr == PTR_AUTOCLR) autoclr = d[7:0];
         else if (ptr < 4'd8) vectors[ptr[2:0]] = d;
      endfunction

      // apply an accepted request and queue the response it should give
      function void note_request(logic [2:0] kind, logic sel, logic [15:0] d,
                                 logic [2:0] src);
         irq_result_type r;
         int          idx;
         logic [7:0]  sel_bit;
         r = '0;
         case (kind)
            REQ_READ: r.rdata = read_register(sel);
            REQ_WRITE: begin
               if (sel) write_command(d);
               else write_data(d);
            end
            REQ_RAISE: begin
               if (int'(src) < NSRC) begin
                  pending = pending | (8'd1 << src);
                  regroup();
               end
            end
            REQ_DROP: begin
               if (int'(src) < NSRC) begin
                  sel_bit = 8'd1 << src;
                  pending = pending & ~sel_bit;
                  in_service = in_service & ~sel_bit;
                  regroup();
               end
            end
            REQ_ACK: begin
               idx = lowest_set(live_bits());
               if (idx >= 0) begin
                  sel_bit = 8'd1 << idx;
                  pending = pending & ~sel_bit;
                  if ((autoclr & sel_bit) != 0) in_service = in_service & ~sel_bit;
                  else in_service = in_service | sel_bit;
                  regroup();
                  r.ack_valid = 1'b1;
                  r.ack_vector = vectors[idx] + base;
               end
            end
            default: ;
         endcase
         r.irq = group[7];
         expected_q.push_back(r);
      endfunction

      function void flag_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
         end
      endfunction

      // compare a response with the oldest expectation
      function void check_response(irq_result_type got);
         irq_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         flag_field("rdata", 16'(want.rdata), 16'(got.rdata));
         flag_field("irq", 16'(want.irq), 16'(got.irq));
         flag_field("ack_valid", 16'(want.ack_valid), 16'(got.ack_valid));
         flag_field("ack_vector", want.ack_vector, got.ack_vector);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   esic_req_if req_chan ();
   esic_rsp_if rsp_chan ();

   irq_scoreboard sb = new();
   bit quiet = 1'b0;
   int idle_cycles = 0;

   eight_source_interrupt_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // watchdog on cycles with no request, response or register access
   always @(negedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || csr_psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL eight_source_interrupt_controller");
         $finish;
      end
   end

   // offer one request and hold it until the block takes it
   task automatic send_request(input logic [2:0] kind, input logic sel,
                               input logic [15:0] d, input logic [2:0] src);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.reg_sel  <= sel;
      req_chan.wdata    <= d;
      req_chan.src      <= src;
      do @(negedge clock); while (!req_chan.ready);
      sb.note_request(kind, sel, d, src);
      @(posedge clock);
   endtask

   task automatic send_cmd(input logic [3:0] code, input logic [3:0] low);
      send_request(REQ_WRITE, 1'b1, {8'h00, code, low}, 3'd0);
   endtask

   // stop offering and wait until every response is back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // write the vector base while idle, then read it back
   task automatic write_base(input logic [15:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= BASE_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      sb.base = value;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $display("%0t: vector base readback mismatch, expected %h, actual %h",
                  $time, CSR_DATA_W'(value), csr_prdata);
         sb.errors++;
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // weighted random request, raise and acknowledge the most frequent kinds
   task automatic random_request(output bit counted);
      int unsigned pick;
      logic [15:0] d;
      logic [3:0]  code;
      logic [2:0]  src;
      pick = $urandom_range(0, 99);
      d = 16'($urandom());
      src = 3'($urandom_range(0, 7));
      counted = 1'b1;
      if (pick < 25) begin
         send_request(REQ_RAISE, d[0], d, src);
      end else if (pick < 45) begin
         send_request(REQ_ACK, d[0], d, src);
      end else if (pick < 55) begin
         send_request(REQ_DROP, d[0], d, src);
      end else if (pick < 68) begin
         send_request(REQ_READ, d[15], d, src);
      end else if (pick < 77) begin
         send_request(REQ_WRITE, 1'b0, d, src);
      end else if (pick < 95) begin
         case ($urandom_range(0, 15))
            0, 1:    code = CMD_CLR_PEND_MSK;
            2, 3:    code = CMD_PTR_MASK;
            4, 5:    code = CMD_PTR_VECTOR;
            6:       code = CMD_PTR_AUTOCLR;
            7:       code = CMD_SET_MASK;
            8:       code = CMD_CLR_PEND;
            9:       code = CMD_CLR_SERVICE;
            10:      code = CMD_MODE_LOW_A;
            11:      code = CMD_MODE_LOW_B;
            12:      code = CMD_MODE_HIGH;
            13:      code = CMD_RESET;
            default: code = 4'($urandom_range(0, 15));
         endcase
         // keep polled mode and master-off rare so irq stays interesting
         if ((code == CMD_MODE_LOW_A || code == CMD_MODE_LOW_B) &&
             $urandom_range(0, 3) != 0) d[2] = 1'b0;
         if (code == CMD_MODE_HIGH && d[1:0] == MASTER_CLR &&
             $urandom_range(0, 1) != 0) d[1:0] = MASTER_SET;
         d[7:4] = code;
         send_request(REQ_WRITE, 1'b1, d, src);
      end else begin
         send_request(3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)), d[0], d, src);
         counted = 1'b0;
      end
   endtask

   // response side: random stalls plus two long hold-offs
   initial begin : receiver
      int unsigned stall;
      int          seen;
      irq_result_type got;
      rsp_chan.ready <= 1'b0;
      seen = 0;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (seen == 200 || seen == 750) stall = LONG_HOLD;
         else if (quiet) stall = 0;
         else stall = $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(negedge clock); while (!rsp_chan.valid);
         got.rdata      = rsp_chan.rdata;
         got.irq        = rsp_chan.irq;
         got.ack_valid  = rsp_chan.ack_valid;
         got.ack_vector = rsp_chan.ack_vector;
         sb.check_response(got);
         seen++;
         @(posedge clock);
      end
   end

   // reset, directed requests, then random phases over several base values
   initial begin : stimulus
      logic [15:0] bases [5];
      int          done;
      bit          counted;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= REQ_READ;
      req_chan.reg_sel  <= 1'b0;
      req_chan.wdata    <= '0;
      req_chan.src      <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with the largest base so vectors wrap
      write_base(16'hFFFF);
      send_request(REQ_READ, 1'b0, 16'h0000, 3'd0);
      send_request(REQ_READ, 1'b1, 16'hFFFF, 3'd7);
      // acknowledge with nothing pending
      send_request(REQ_ACK, 1'b0, 16'h0000, 3'd0);
      send_cmd(CMD_PTR_MASK, 4'h0);
      send_request(REQ_WRITE, 1'b0, 16'h0000, 3'd0);
      // upper byte and bit 3 ignored on a pointer command
      send_request(REQ_WRITE, 1'b1, {8'hFF, CMD_PTR_VECTOR, 4'hF}, 3'd0);
      send_request(REQ_WRITE, 1'b0, 16'hFFFF, 3'd0);
      send_cmd(CMD_PTR_VECTOR, 4'h0);
      send_request(REQ_WRITE, 1'b0, 16'h0001, 3'd0);
      send_request(REQ_RAISE, 1'b0, 16'h0000, 3'd7);
      send_request(REQ_RAISE, 1'b1, 16'hFFFF, 3'd0);
      send_request(REQ_ACK, 1'b0, 16'h0000, 3'd0);
      send_request(REQ_READ, 1'b1, 16'h0000, 3'd0);
      send_cmd(CMD_PTR_AUTOCLR, 4'h0);
      send_request(REQ_WRITE, 1'b0, 16'h00FF, 3'd0);
      send_request(REQ_ACK, 1'b1, 16'hFFFF, 3'd7);
      // unknown request kinds
      send_request(REQ_UNUSED_FIRST, 1'b1, 16'hFFFF, 3'd7);
      send_request(REQ_UNUSED_LAST, 1'b0, 16'h0000, 3'd0);
      // spare command code does nothing
      send_cmd(CMD_SPARE, 4'hF);
      send_cmd(CMD_MODE_HIGH, {2'b01, MASTER_SET});
      send_request(REQ_READ, 1'b0, 16'h0000, 3'd0);
      // polled mode hides the group interrupt
      send_cmd(CMD_MODE_LOW_A, 4'b0101);
      send_request(REQ_RAISE, 1'b0, 16'h0000, 3'd3);
      send_request(REQ_READ, 1'b1, 16'h0000, 3'd0);
      send_request(REQ_DROP, 1'b0, 16'h0000, 3'd3);
      send_cmd(CMD_RESET, 4'h0);

      // random phases
      bases[0] = 16'h0000;
      bases[1] = 16'hFFFF;
      bases[2] = 16'h8000;
      bases[3] = 16'($urandom());
      bases[4] = 16'h0001;
      for (int p = 0; p < 5; p++) begin
         write_base(bases[p]);
         done = 0;
         while (done < PHASE_REQUESTS) begin
            quiet = (done >= 60 && done < 100);
            random_request(counted);
            if (counted) begin
               done++;
               if (done == 150) wait_drained();
            end
         end
      end

      wait_drained();
      if (sb.errors == 0) begin
         $display("PASS eight_source_interrupt_controller");
      end else begin
         $display("FAIL eight_source_interrupt_controller");
      end
      $finish;
   end

endmodule
